[design/wgm_pkg.sv]
// ----------------------------------------------------------------------------
// wgm_pkg
// Shared constants for the wildcard glob matcher: character codes, pattern
// storage layout and configuration register indexes.
// ----------------------------------------------------------------------------
package wgm_pkg;

  localparam int CHAR_W      = 8;
  localparam int WORD_W      = 64;
  localparam int WORD_COUNT  = 6;
  localparam int CHARS_WORD  = WORD_W / CHAR_W;
  localparam int CHARS_HELD  = WORD_COUNT * CHARS_WORD;
  localparam int LEN_FIELD_W = 6;
  localparam int WORD_IDX_W  = $clog2(WORD_COUNT);
  localparam int CFG_INDEX_W = 3;

  localparam logic [CHAR_W-1:0] STAR_CHAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] ANY_CHAR    = 8'h3F;
  localparam logic [CHAR_W-1:0] LOWER_A     = 8'h61;
  localparam logic [CHAR_W-1:0] LOWER_Z     = 8'h7A;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;

  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_FIRST = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHARS_LAST  = CFG_INDEX_W'(WORD_COUNT);

endpackage

[design/wgm_star_scan.sv]
// ----------------------------------------------------------------------------
// wgm_star_scan
// Star closure over the active-position vector as a log-depth prefix scan:
// a set position carries forward through every following star.
// ----------------------------------------------------------------------------
module wgm_star_scan #(
  parameter int WIDTH = 49
) (
  input  logic [WIDTH-1:0] active_in,
  input  logic [WIDTH-1:0] carry_in,
  output logic [WIDTH-1:0] closed
);

  localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] gen_lvl  [0:LEVELS];
  logic [WIDTH-1:0] prop_lvl [0:LEVELS];

  // carry_in[j] set: a set bit at j-1 also sets bit j
  always_comb begin
    gen_lvl[0]  = active_in;
    prop_lvl[0] = carry_in;
    for (int lv = 0; lv < LEVELS; lv++) begin
      for (int j = 0; j < WIDTH; j++) begin
        if (j >= (1 << lv)) begin
          gen_lvl[lv+1][j]  = gen_lvl[lv][j] |
                              (prop_lvl[lv][j] & gen_lvl[lv][j - (1 << lv)]);
          prop_lvl[lv+1][j] = prop_lvl[lv][j] & prop_lvl[lv][j - (1 << lv)];
        end else begin
          gen_lvl[lv+1][j]  = gen_lvl[lv][j];
          prop_lvl[lv+1][j] = prop_lvl[lv][j];
        end
      end
    end
  end

  assign closed = gen_lvl[LEVELS];

endmodule

[design/wildcard_glob_matcher_unit.sv]
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_unit
// Streaming glob matcher: file name characters in, one verdict per name out.
// ----------------------------------------------------------------------------
// The block takes one name character per clock, back to back, and presents a
// matched flag from the result register after the end transaction is accepted.
// Each transaction passes an input register, then logic that updates the
// active-position vector (star closure, character compare, star closure)
// and, for an end transaction, loads the result register. The only wait is
// an end transaction whose verdict would overwrite a result still stalled at
// the output. Load the pattern length (register 0) and the pattern words
// (registers 1 to 6, eight characters each, lowest index in the low byte)
// between names; '*' matches any run, '?' any one character, letters a-z of
// the name are upper-cased before compare.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_unit
  import wgm_pkg::*;
#(
  parameter int PATTERN_MAX = 48
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CHAR_W-1:0]      name_char,
  input  logic                   is_end,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   matched,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]      cfg_data
);

  localparam int POS_W = PATTERN_MAX + 1;
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  // configuration
  logic [LEN_FIELD_W-1:0] pattern_length;
  logic [WORD_W-1:0]      pat_words [0:WORD_COUNT-1];

  // input stage
  logic              r_valid;
  logic [CHAR_W-1:0] r_char;
  logic              r_end;

  logic [POS_W-1:0] state;

  logic [LEN_W-1:0]  eff_len;
  logic [CHAR_W-1:0] ch_up;
  logic [CHAR_W-1:0] pch [0:PATTERN_MAX-1];
  logic [PATTERN_MAX-1:0] is_star, in_use, hit;
  logic [POS_W-1:0] keep, carry, masked, pre_closed;
  logic [POS_W-1:0] step_next, post_in, post_closed;
  logic advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      for (int k = 0; k < WORD_COUNT; k++) begin
        pat_words[k] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_LENGTH) begin
        pattern_length <= cfg_data[LEN_FIELD_W-1:0];
      end else if (cfg_index >= CFG_CHARS_FIRST && cfg_index <= CFG_CHARS_LAST) begin
        pat_words[WORD_IDX_W'(cfg_index - CFG_CHARS_FIRST)] <= cfg_data;
      end
    end
  end

  always_comb begin
    if (int'(pattern_length) > PATTERN_MAX) begin
      eff_len = LEN_W'(PATTERN_MAX);
    end else begin
      eff_len = LEN_W'(pattern_length);
    end
  end

  assign ch_up = (r_char >= LOWER_A && r_char <= LOWER_Z) ? r_char - CASE_OFFSET : r_char;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    if (i < CHARS_HELD) begin : g_held
      assign pch[i] = pat_words[i / CHARS_WORD][(i % CHARS_WORD) * CHAR_W +: CHAR_W];
    end else begin : g_none
      assign pch[i] = '0;
    end
    assign is_star[i] = (pch[i] == STAR_CHAR);
    assign in_use[i]  = (eff_len > LEN_W'(i));
    assign hit[i]     = (pch[i] == ANY_CHAR) || (pch[i] == ch_up);
  end

  // a star position stays active on any character
  for (genvar j = 0; j < POS_W; j++) begin : g_vec
    assign keep[j] = (LEN_W'(j) <= eff_len) || (j == 0);
    if (j == 0) begin : g_first
      assign carry[j]     = 1'b0;
      assign step_next[j] = pre_closed[j] & in_use[j] & is_star[j];
    end else if (j == PATTERN_MAX) begin : g_last
      assign carry[j]     = is_star[j-1] & in_use[j-1];
      assign step_next[j] = pre_closed[j-1] & in_use[j-1] & ~is_star[j-1] & hit[j-1];
    end else begin : g_mid
      assign carry[j]     = is_star[j-1] & in_use[j-1];
      assign step_next[j] = (pre_closed[j] & in_use[j] & is_star[j]) |
                            (pre_closed[j-1] & in_use[j-1] & ~is_star[j-1] & hit[j-1]);
    end
  end

  assign masked = state & keep;

  wgm_star_scan #(.WIDTH(POS_W)) u_pre_scan (
    .active_in (masked),
    .carry_in  (carry),
    .closed    (pre_closed)
  );

  // an end transaction restarts from position zero
  assign post_in = r_end ? POS_W'(1) : step_next;

  wgm_star_scan #(.WIDTH(POS_W)) u_post_scan (
    .active_in (post_in),
    .carry_in  (carry),
    .closed    (post_closed)
  );

  assign advance  = r_valid && (!r_end || !out_valid || !out_stall);
  assign in_stall = r_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid   <= 1'b0;
      state     <= POS_W'(1);
      out_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        r_valid <= 1'b1;
      end else if (advance) begin
        r_valid <= 1'b0;
      end
      if (advance) begin
        state <= post_closed;
      end
      if (advance && r_end) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      r_char <= name_char;
      r_end  <= is_end;
    end
    if (advance && r_end) begin
      matched <= pre_closed[eff_len];
    end
  end

  a_restart_pos0 : assert property (@(posedge clk) disable iff (rst)
    advance && r_end |=> state[0])
    else $error("position zero not active after end of name");

  a_no_pos_past_len : assert property (@(posedge clk) disable iff (rst)
    advance |=> ((state >> $past(eff_len)) >> 1) == '0)
    else $error("active position beyond pattern length");

  a_char_never_waits : assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_end |-> !in_stall)
    else $error("name character held back");

  a_result_from_end : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && r_end))
    else $error("result without end transaction");

endmodule

[tb/sv/wildcard_glob_matcher_unit_tb.sv]
// ----------------------------------------------------------------------------
// wildcard_glob_matcher_unit_tb
// Self-checking bench for the streaming wildcard glob matcher.
// ----------------------------------------------------------------------------
// A behavioral copy of the active-position matcher predicts the verdict for
// every name ending. A monitor compares each verdict transaction with the
// oldest prediction. Directed names cover stars, question marks, case folding,
// zero and all-ones bytes, an oversize length and a pattern swapped mid-name.
// Random names built from random patterns follow under changing idle and stall.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_unit_tb;
  import wgm_pkg::*;

  localparam int PATTERN_MAX  = 48;
  localparam int DRAIN_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 400000;

  typedef bit [CHAR_W-1:0] char_q_t[$];
  typedef bit [WORD_W-1:0] word_set_t[WORD_COUNT];

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [CHAR_W-1:0]      name_char = '0;
  logic                   is_end    = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   matched;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]      cfg_data  = '0;

  wildcard_glob_matcher_unit #(
    .PATTERN_MAX(PATTERN_MAX)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .name_char(name_char),
    .is_end   (is_end),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .matched  (matched),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the pattern registers and the active-position vector
  bit [LEN_FIELD_W-1:0] shadow_length;
  word_set_t            shadow_words;
  bit [PATTERN_MAX:0]   live_positions = 1;
  bit                   verdict_queue[$];

  int send_idle_pct  = 0;
  int stall_pct      = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  function automatic int effective_length();
    return (shadow_length > PATTERN_MAX) ? PATTERN_MAX : int'(shadow_length);
  endfunction

  function automatic bit [CHAR_W-1:0] pattern_byte(int pos);
    if (pos >= CHARS_HELD) return '0;
    return shadow_words[pos / CHARS_WORD][(pos % CHARS_WORD) * CHAR_W +: CHAR_W];
  endfunction

  // Drop positions past the length, then let each live star open the next one
  function automatic void close_stars(int len);
    for (int i = len + 1; i <= PATTERN_MAX; i++) live_positions[i] = 1'b0;
    for (int i = 0; i < len; i++)
      if (live_positions[i] && pattern_byte(i) == STAR_CHAR) live_positions[i + 1] = 1'b1;
  endfunction

  function automatic void advance_matcher(bit [CHAR_W-1:0] ch, bit end_flag);
    int                 len;
    bit [CHAR_W-1:0]    folded;
    bit [CHAR_W-1:0]    pc;
    bit [PATTERN_MAX:0] next_live;
    len = effective_length();
    close_stars(len);
    if (end_flag) begin
      verdict_queue.push_back(live_positions[len]);
      live_positions = 1;
      close_stars(len);
      return;
    end
    folded = (ch >= LOWER_A && ch <= LOWER_Z) ? ch - CASE_OFFSET : ch;
    next_live = '0;
    for (int i = 0; i < len; i++) begin
      pc = pattern_byte(i);
      if (live_positions[i]) begin
        if (pc == STAR_CHAR) next_live[i] = 1'b1;
        else if (pc == ANY_CHAR || pc == folded) next_live[i + 1] = 1'b1;
      end
    end
    live_positions = next_live;
    close_stars(len);
  endfunction

  task automatic report_mismatch(string what, logic want, logic got);
    $display("mismatch at cycle %0d: %s, expected %b, got %b", cycle_count, what, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : verdict_monitor
    bit want;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_queue.size() == 0) begin
        report_mismatch("verdict with no name ended", 1'b0, matched);
      end else begin
        want = verdict_queue.pop_front();
        if (matched !== want) report_mismatch("matched", want, matched);
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Leaves in_valid high on return; a drain, or an idle in the next call, lowers it
  task automatic send_char(bit [CHAR_W-1:0] ch, bit end_flag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    name_char <= ch;
    is_end    <= end_flag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_matcher(ch, end_flag);
  endtask

  task automatic send_name(char_q_t chars);
    foreach (chars[i]) send_char(chars[i], 1'b0);
    send_char(8'($urandom_range(255)), 1'b1);
  endtask

  // Hold off until every verdict is back and the pipeline has emptied
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high; load_words lowers it after the last write
  task automatic write_reg(bit [CFG_INDEX_W-1:0] idx, bit [WORD_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_LENGTH) shadow_length = data[LEN_FIELD_W-1:0];
    else shadow_words[idx - CFG_CHARS_FIRST] = data;
  endtask

  task automatic load_words(bit [LEN_FIELD_W-1:0] len_value, word_set_t words);
    wait_quiet();
    write_reg(CFG_LENGTH, WORD_W'(len_value));
    for (int k = 0; k < WORD_COUNT; k++)
      write_reg(CFG_INDEX_W'(CFG_CHARS_FIRST + k), words[k]);
    cfg_valid <= 1'b0;
  endtask

  // Fill the bytes past the pattern with noise
  task automatic load_pattern(char_q_t chars, bit [LEN_FIELD_W-1:0] len_value);
    word_set_t words;
    foreach (words[k]) words[k] = {$urandom, $urandom};
    for (int i = 0; i < chars.size() && i < CHARS_HELD; i++)
      words[i / CHARS_WORD][(i % CHARS_WORD) * CHAR_W +: CHAR_W] = chars[i];
    load_words(len_value, words);
  endtask

  function automatic char_q_t text_bytes(string s);
    char_q_t bytes;
    for (int i = 0; i < s.len(); i++) bytes.push_back(s[i]);
    return bytes;
  endfunction

  function automatic bit [CHAR_W-1:0] noise_char();
    string pool;
    pool = "ABCDabcd.*?";
    if ($urandom_range(1)) return 8'($urandom_range(255));
    return pool[$urandom_range(pool.len() - 1)];
  endfunction

  function automatic bit [CHAR_W-1:0] random_pattern_char();
    string pool;
    pool = "ABCDEF.0";
    case ($urandom_range(9))
      0, 1:    return STAR_CHAR;
      2, 3:    return ANY_CHAR;
      4:       return 8'($urandom_range(255));
      default: return pool[$urandom_range(pool.len() - 1)];
    endcase
  endfunction

  function automatic void random_pattern(output char_q_t pat,
                                         output bit [LEN_FIELD_W-1:0] len_value);
    int n;
    pat = {};
    if ($urandom_range(19) == 0) len_value = LEN_FIELD_W'($urandom_range(40, 63));
    else len_value = LEN_FIELD_W'($urandom_range(0, 8));
    n = (len_value > PATTERN_MAX) ? PATTERN_MAX : int'(len_value);
    repeat (n) pat.push_back(random_pattern_char());
  endfunction

  // Mostly names that fit the pattern, some broken, some pure noise
  function automatic char_q_t random_name(char_q_t pat);
    char_q_t nm;
    int      pick;
    int      idx;
    pick = $urandom_range(99);
    if (pick < 15) begin
      repeat ($urandom_range(0, 6)) nm.push_back(noise_char());
      return nm;
    end
    foreach (pat[i]) begin
      if (pat[i] == STAR_CHAR) repeat ($urandom_range(0, 3)) nm.push_back(noise_char());
      else if (pat[i] == ANY_CHAR) nm.push_back(8'($urandom_range(255)));
      else if (pat[i] >= "A" && pat[i] <= "Z" && $urandom_range(1))
        nm.push_back(pat[i] + CASE_OFFSET);
      else nm.push_back(pat[i]);
    end
    if (pick < 30 && nm.size() != 0) begin
      idx = $urandom_range(nm.size() - 1);
      if ($urandom_range(1)) nm[idx] = 8'($urandom_range(255));
      else nm.delete(idx);
    end else if (pick < 35) begin
      nm.push_back(noise_char());
    end
    return nm;
  endfunction

  task automatic test_wildcards();
    load_pattern(text_bytes(""), 0);
    send_name(text_bytes(""));
    send_name(text_bytes("x"));
    load_pattern(text_bytes("*.TXT"), 5);
    send_name(text_bytes("ab.txt"));
    send_name(text_bytes(".TX"));
    load_pattern(text_bytes("A?C"), 3);
    send_name(text_bytes("abc"));
    send_name(text_bytes("AC"));
    load_pattern(text_bytes("**X"), 3);
    send_name(text_bytes("x"));
    // only a-z fold; the neighbors of the range stay as they are
    load_pattern(text_bytes("`AZ{"), 4);
    send_name(text_bytes("`az{"));
    load_pattern(text_bytes("a"), 1);
    send_name(text_bytes("a"));
  endtask

  task automatic test_special_bytes();
    word_set_t words;
    char_q_t   seq;
    foreach (words[k]) words[k] = '1;
    load_words(1, words);
    seq = {8'hFF};
    send_name(seq);
    seq = {8'hFE};
    send_name(seq);
    foreach (words[k]) words[k] = '0;
    load_words(3, words);
    seq = {8'h00, 8'h00, 8'h00};
    send_name(seq);
    seq = {8'h00, 8'h00};
    send_name(seq);
    seq = {8'h41, 8'h00, 8'h42};
    load_pattern(seq, 3);
    seq = {8'h61, 8'h00, 8'h62};
    send_name(seq);
    // oversize length clamps to the stored characters, all stars here
    foreach (words[k]) words[k] = {CHARS_WORD{STAR_CHAR}};
    load_words(63, words);
    send_name(text_bytes(""));
    seq = {8'hFF, 8'h00};
    send_name(seq);
  endtask

  task automatic test_pattern_swap_mid_name();
    load_pattern(text_bytes("A*C"), 3);
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    load_pattern(text_bytes("AB"), 2);
    send_char(8'($urandom_range(255)), 1'b1);
    // then shrink mid-name to a single star so positions past the new length are dropped
    load_pattern(text_bytes("ABC"), 3);
    send_char("a", 1'b0);
    send_char("b", 1'b0);
    load_pattern(text_bytes("*"), 1);
    send_char("x", 1'b0);
    send_char(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic test_random_names(int item_goal, int idle_level, int stall_level);
    int                   sent;
    char_q_t              pat;
    char_q_t              nm;
    bit [LEN_FIELD_W-1:0] len_value;
    sent = 0;
    wait_quiet();
    send_idle_pct = idle_level;
    stall_pct     = stall_level;
    while (sent < item_goal) begin
      random_pattern(pat, len_value);
      load_pattern(pat, len_value);
      repeat ($urandom_range(2, 5)) begin
        nm = random_name(pat);
        send_name(nm);
        sent += nm.size() + 1;
      end
    end
    wait_quiet();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_wildcards();
    test_special_bytes();
    test_pattern_swap_mid_name();
    test_random_names(120, 0, 0);
    test_random_names(100, 78, 0);
    test_random_names(100, 0, 78);
    test_random_names(90, 11, 11);
    wait_quiet();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
